>>> rtl/wspm_pkg.sv
package wspm_pkg;

    localparam int unsigned MAX_PATTERN_DEF = 32;

    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] ANY_BYTE  = 8'h2E;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TEXT   = 2'd2,
        CMD_FINISH = 2'd3
    } t_cmd;

    // broadcast to every cell on each cycle
    typedef struct packed {
        logic       go;      // input beat taken this cycle
        logic       rearm;   // restart at position zero (any command but text)
        logic       append;  // pattern byte being written
        logic [7:0] symbol;
    } t_cell_ctl;

endpackage

>>> rtl/wspm_cell.sv
module wspm_cell #(
    parameter int unsigned MAX_PATTERN = wspm_pkg::MAX_PATTERN_DEF,
    parameter int unsigned IDX         = 0,
    localparam int unsigned LW         = $clog2(MAX_PATTERN + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  wspm_pkg::t_cell_ctl  i_ctl,
    input  logic [LW-1:0]        i_len,        // current pattern length
    input  logic [LW-1:0]        i_len_n,      // length after this beat
    input  logic                 i_fwd,        // step in from position IDX-1
    input  logic                 i_clo_prev2,  // closed next bit of position IDX-2
    input  logic                 i_star_prev,  // position IDX-2 is starred
    input  logic                 i_star_next,  // this position is starred
    output logic                 o_fwd,
    output logic                 o_clo,
    output logic                 o_star,       // own byte is '*' within pattern
    output logic                 o_act
);
    import wspm_pkg::*;

    logic [7:0] r_sym;
    logic [7:0] n_sym;
    logic       r_act;
    logic       w_wr;
    logic       w_hit;
    logic       w_raw;

    assign w_wr   = i_ctl.go && i_ctl.append && (i_len == LW'(IDX));
    assign n_sym  = w_wr ? i_ctl.symbol : r_sym;
    assign o_star = (LW'(IDX) < i_len_n) && (n_sym == STAR_BYTE);

    // live position whose byte takes the text byte
    assign w_hit = r_act && (LW'(IDX) < i_len)
                && ((r_sym == ANY_BYTE) || (r_sym == i_ctl.symbol));

    assign o_fwd = w_hit && !i_star_next;
    assign w_raw = i_ctl.rearm ? (IDX == 0) : ((w_hit && i_star_next) || i_fwd);
    // star closure ripples two positions at a time along the row
    assign o_clo = w_raw || (i_clo_prev2 && i_star_prev);
    assign o_act = r_act;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_sym <= i_ctl.symbol;
        end
        if (!i_rst_n) begin
            r_act <= (IDX == 0);
        end else if (i_ctl.go) begin
            r_act <= o_clo;
        end
    end

endmodule

>>> rtl/wildcard_star_pattern_matcher.sv
// Whole-string matcher for patterns with '.' (any byte) and 'x*' (zero or
// more of x). Each input beat carries a command: clear the pattern, append a
// pattern byte, feed a text byte, or finish the text. Only a finish beat gives
// a result beat (matched, overflow) and then rearms for a fresh text on the
// same pattern; clear and append also drop any text in progress. A byte
// appended beyond MAX_PATTERN is dropped and flags overflow, which forces
// matched low until the next clear. One beat is taken every cycle while
// input stall is low; a finish result is registered into the output buffer.
// The pattern lives in a row of MAX_PATTERN cells, one per position, each
// holding its byte and its active bit, plus a final end-of-pattern bit; the
// star closure ripples combinationally along that row and sets the critical
// path (about MAX_PATTERN/2 cell hops). A two-deep output buffer decouples
// the sides: input stall rises only while two results wait to be taken.
module wildcard_star_pattern_matcher #(
    parameter int unsigned MAX_PATTERN = wspm_pkg::MAX_PATTERN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_command,
    input  logic [7:0] i_symbol,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_matched,
    output logic       o_overflow
);
    import wspm_pkg::*;

    localparam int unsigned LW = $clog2(MAX_PATTERN + 1);

    t_cmd          w_cmd;
    t_cell_ctl     w_ctl;
    logic          w_go;
    logic          w_push;
    logic          w_pop;

    logic [LW-1:0] r_len;
    logic [LW-1:0] n_len;
    logic          r_ovf;
    logic          n_ovf;
    logic          r_act_end;
    logic          n_act_end;
    logic          w_full;

    logic          w_fwd  [MAX_PATTERN];
    logic          w_clo  [MAX_PATTERN];
    logic          w_star [MAX_PATTERN];
    logic          w_act  [MAX_PATTERN + 1];
    logic          w_final;

    // output buffer: main stage and skid stage
    logic          r_out_v;
    logic          r_out_m;
    logic          r_out_o;
    logic          r_skid_v;
    logic          r_skid_m;
    logic          r_skid_o;
    logic          w_res_m;

    assign w_cmd      = t_cmd'(i_command);
    assign o_in_stall = r_skid_v;
    assign w_go       = i_in_valid && !r_skid_v;

    assign w_ctl.go     = w_go;
    assign w_ctl.rearm  = (w_cmd != CMD_TEXT);
    assign w_ctl.append = (w_cmd == CMD_APPEND);
    assign w_ctl.symbol = i_symbol;

    assign w_full = (r_len == LW'(MAX_PATTERN));

    // pattern length and overflow flag as seen after this beat
    always_comb begin
        n_len = r_len;
        n_ovf = r_ovf;
        if (w_go) begin
            case (w_cmd)
                CMD_CLEAR: begin
                    n_len = '0;
                    n_ovf = 1'b0;
                end
                CMD_APPEND: begin
                    if (w_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_len = r_len + LW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // row of position cells; cell p talks to p-1, p+1 and (closure) p-2
    for (genvar p = 0; p < MAX_PATTERN; p++) begin : g_cell
        logic w_fwd_in;
        logic w_clo_in;
        logic w_star_prev;
        logic w_star_next;

        if (p == 0) begin : g_first
            assign w_fwd_in = 1'b0;
        end else begin : g_link
            assign w_fwd_in = w_fwd[p-1];
        end

        if (p < 2) begin : g_head
            assign w_clo_in    = 1'b0;
            assign w_star_prev = 1'b0;
        end else begin : g_body
            assign w_clo_in    = w_clo[p-2];
            assign w_star_prev = w_star[p-1];
        end

        if (p == MAX_PATTERN - 1) begin : g_tail
            assign w_star_next = 1'b0;
        end else begin : g_next
            assign w_star_next = w_star[p+1];
        end

        wspm_cell #(
            .MAX_PATTERN (MAX_PATTERN),
            .IDX         (p)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_len       (r_len),
            .i_len_n     (n_len),
            .i_fwd       (w_fwd_in),
            .i_clo_prev2 (w_clo_in),
            .i_star_prev (w_star_prev),
            .i_star_next (w_star_next),
            .o_fwd       (w_fwd[p]),
            .o_clo       (w_clo[p]),
            .o_star      (w_star[p]),
            .o_act       (w_act[p])
        );
    end

    // end-of-pattern position: reached by stepping or by closure only
    assign n_act_end = (!w_ctl.rearm && w_fwd[MAX_PATTERN-1])
                    || (w_clo[MAX_PATTERN-2] && w_star[MAX_PATTERN-1]);
    assign w_act[MAX_PATTERN] = r_act_end;

    assign w_final = w_act[r_len];
    assign w_res_m = w_final && !r_ovf;

    assign w_push = w_go && (w_cmd == CMD_FINISH);
    assign w_pop  = r_out_v && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_ovf     <= 1'b0;
            r_act_end <= 1'b0;
            r_out_v   <= 1'b0;
            r_skid_v  <= 1'b0;
        end else begin
            r_len <= n_len;
            r_ovf <= n_ovf;
            if (w_go) begin
                r_act_end <= n_act_end;
            end

            if (r_skid_v) begin
                // input held off; drain skid into main stage
                if (w_pop) begin
                    r_out_m  <= r_skid_m;
                    r_out_o  <= r_skid_o;
                    r_skid_v <= 1'b0;
                end
            end else if (w_push) begin
                if (!r_out_v || w_pop) begin
                    r_out_v <= 1'b1;
                    r_out_m <= w_res_m;
                    r_out_o <= r_ovf;
                end else begin
                    r_skid_v <= 1'b1;
                    r_skid_m <= w_res_m;
                    r_skid_o <= r_ovf;
                end
            end else if (w_pop) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_matched   = r_out_m;
    assign o_overflow  = r_out_o;

`ifndef SYNTHESIS
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid stage holds a beat while the main stage is empty");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(MAX_PATTERN))
        else $error("pattern length beyond store");

    a_ovf_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflow) |-> !o_matched)
        else $error("match reported on an overflowed pattern");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && (w_cmd == CMD_CLEAR)) |=> ((r_len == '0) && !r_ovf && w_act[0]))
        else $error("clear did not reset the pattern state");
`endif

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import wspm_pkg::*;

    localparam int unsigned MAX_PAT      = MAX_PATTERN_DEF;
    localparam int unsigned RAND_ITEMS   = 800;
    localparam int unsigned HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int unsigned STALL_LIMIT  = 2000;  // cycles with no beat on either side
    localparam int unsigned DRAIN_CYCLES = 8;     // wait for stray result beats after the last verdict
    localparam int unsigned REPORT_MAX   = 10;

    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_C = 8'h63;

    typedef struct packed {
        logic matched;
        logic overflow;
    } t_verdict;

    // one line of the directed sequence; 'fixed' rows carry their verdict,
    // the rest take it from the predictor
    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] sym;
        logic [5:0] reps;
        logic       fixed;
        t_verdict   want;
    } t_row;

    localparam int unsigned N_ROWS = 30;

    // ------------------------------------------------------------------
    // DUT hookup; every input known from time zero
    // ------------------------------------------------------------------
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [1:0] i_command   = CMD_CLEAR;
    logic [7:0] i_symbol    = 8'h00;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_matched;
    logic       o_overflow;

    wildcard_star_pattern_matcher u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_symbol    (i_symbol),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_matched   (o_matched),
        .o_overflow  (o_overflow)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Matcher state as the testbench sees it
    // ------------------------------------------------------------------
    logic [7:0]       pat_mem [MAX_PAT];
    int unsigned      pat_len = 0;
    logic             pat_ovf = 1'b0;
    logic [MAX_PAT:0] live_pos;         // active positions 0..pat_len
    t_verdict         pending_verdicts [$];

    int unsigned n_bad       = 0;
    int unsigned beats_taken = 0;
    int unsigned burst_left  = 0;
    int unsigned idle_cycles = 0;
    t_verdict    got_verdict;
    t_verdict    want_verdict;

    // receiver stall pattern
    bit          hold_req  = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned hold_left = 0;
    int unsigned mode_left = 0;
    int unsigned stall_pct = 0;

    // pattern byte p followed by a star byte: p is a starred unit
    function automatic logic starred(int unsigned p);
        return (p + 1 < pat_len) && (pat_mem[p + 1] == STAR_BYTE);
    endfunction

    // a live starred unit may be skipped: light the position two on
    function automatic logic [MAX_PAT:0] close_stars(logic [MAX_PAT:0] v);
        for (int unsigned p = 0; p < pat_len; p++) begin
            if (v[p] && starred(p))
                v[p + 2] = 1'b1;
        end
        return v;
    endfunction

    function automatic logic [MAX_PAT:0] fresh_positions();
        return close_stars({{MAX_PAT{1'b0}}, 1'b1});
    endfunction

    // advance the matcher by one accepted beat; a finish queues its verdict
    task automatic verdict_step(input t_cmd cmd, input logic [7:0] sym,
                                input logic fixed, input t_verdict want);
        logic [MAX_PAT:0] nxt;
        t_verdict         v;
        case (cmd)
            CMD_CLEAR: begin
                pat_len  = 0;
                pat_ovf  = 1'b0;
                live_pos = fresh_positions();
            end
            CMD_APPEND: begin
                if (pat_len < MAX_PAT) begin
                    pat_mem[pat_len] = sym;
                    pat_len++;
                end else begin
                    pat_ovf = 1'b1;     // store full, byte dropped
                end
                live_pos = fresh_positions();
            end
            CMD_TEXT: begin
                nxt = '0;
                for (int unsigned p = 0; p < pat_len; p++) begin
                    if (live_pos[p] && (pat_mem[p] == ANY_BYTE || pat_mem[p] == sym)) begin
                        if (starred(p))
                            nxt[p] = 1'b1;
                        else
                            nxt[p + 1] = 1'b1;
                    end
                end
                live_pos = close_stars(nxt);
            end
            default: begin
                v.matched  = live_pos[pat_len] && !pat_ovf;
                v.overflow = pat_ovf;
                pending_verdicts.push_back(fixed ? want : v);
                live_pos = fresh_positions();
            end
        endcase
    endtask

    // offer one beat; bursts of random length with random gaps between them
    task automatic send_beat(input t_cmd cmd, input logic [7:0] sym,
                             input logic fixed = 1'b0, input t_verdict want = '0);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                      : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_symbol   <= sym;
        do @(posedge i_clk); while (o_in_stall);
        beats_taken++;
        verdict_step(cmd, sym, fixed, want);
    endtask

    function automatic logic [7:0] pick_pat_byte();
        case ($urandom_range(0, 9))
            0, 1, 2: return CH_A;
            3, 4:    return CH_B;
            5:       return ANY_BYTE;
            6, 7:    return STAR_BYTE;
            8:       return CH_C;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_text_byte();
        case ($urandom_range(0, 7))
            0, 1, 2: return CH_A;
            3, 4:    return CH_B;
            5:       return CH_C;
            6:       return ($urandom_range(0, 1) != 0) ? STAR_BYTE : ANY_BYTE;
            default: return 8'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Directed sequence
    // ------------------------------------------------------------------
    t_row dir_tab [N_ROWS] = '{
        // empty pattern: empty text matches, a non-empty one does not
        '{CMD_FINISH, 8'h00,     6'd1,  1'b1, '{1'b1, 1'b0}},
        '{CMD_TEXT,   8'hFF,     6'd1,  1'b0, '{1'b0, 1'b0}},
        '{CMD_FINISH, 8'h00,     6'd1,  1'b1, '{1'b0, 1'b0}},
        // "*a*": leading star is a plain literal, then a starred 'a'
        '{CMD_APPEND, STAR_BYTE, 6'd1,  1'b0, '{1'b0, 1'b0}},
        '{CMD_APPEND, CH_A,      6'd1,  1'b0, '{1'b0, 1'b0}},
        '{CMD_APPEND, STAR_BYTE, 6'd1,  1'b0, '{1'b0, 1'b0}},
        '{CMD_TEXT,   STAR_BYTE, 6'd1,  1'b0, '{1'b0, 1'b0}},
        '{CMD_TEXT,   CH_A,      6'd1,  1'b0, '{1'b0, 1'b0}},
        '{CMD_TEXT,   CH_A,      6'd1,  1'b0, '{1'b0, 1'b0}},
        '{CMD_FINISH, 8'h00,     6'd1,  1'b0, '{1'b0, 1'b0}},
        '{CMD_FINISH, 8'hFF,     6'd1,  1'b0, '{1'b0, 1'b0}},
        // ".*" against extreme byte values
        '{CMD_CLEAR,  8'hFF,     6'd1,  1'b0, '{1'b0, 1'b0}},
        '{CMD_APPEND, ANY_BYTE,  6'd1,  1'b0, '{1'b0, 1'b0}},
        '{CMD_APPEND, STAR_BYTE, 6'd1,  1'b0, '{1'b0, 1'b0}},
        '{CMD_TEXT,   8'h00,     6'd1,  1'b0, '{1'b0, 1'b0}},
        '{CMD_TEXT,   8'hFF,     6'd1,  1'b0, '{1'b0, 1'b0}},
        '{CMD_FINISH, 8'h00,     6'd1,  1'b0, '{1'b0, 1'b0}},
        // pattern grows mid-text: the text so far is thrown away
        '{CMD_TEXT,   CH_A,      6'd1,  1'b0, '{1'b0, 1'b0}},
        '{CMD_APPEND, CH_B,      6'd1,  1'b0, '{1'b0, 1'b0}},
        '{CMD_TEXT,   CH_B,      6'd1,  1'b0, '{1'b0, 1'b0}},
        '{CMD_FINISH, 8'h00,     6'd1,  1'b0, '{1'b0, 1'b0}},
        // store exactly full, then one byte too many
        '{CMD_CLEAR,  8'h00,     6'd1,  1'b0, '{1'b0, 1'b0}},
        '{CMD_APPEND, ANY_BYTE,  6'd32, 1'b0, '{1'b0, 1'b0}},
        '{CMD_TEXT,   8'h5A,     6'd32, 1'b0, '{1'b0, 1'b0}},
        '{CMD_FINISH, 8'h00,     6'd1,  1'b0, '{1'b0, 1'b0}},
        '{CMD_APPEND, 8'h00,     6'd1,  1'b0, '{1'b0, 1'b0}},
        '{CMD_FINISH, 8'h00,     6'd1,  1'b1, '{1'b0, 1'b1}},
        '{CMD_FINISH, 8'hFF,     6'd1,  1'b1, '{1'b0, 1'b1}},
        // clear drops the overflow flag
        '{CMD_CLEAR,  8'h00,     6'd1,  1'b0, '{1'b0, 1'b0}},
        '{CMD_FINISH, 8'h00,     6'd1,  1'b1, '{1'b1, 1'b0}}
    };

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int unsigned dir_beats;
        int unsigned sel;
        int unsigned n;
        int unsigned p;
        logic [7:0]  b;

        for (int unsigned k = 0; k < MAX_PAT; k++)
            pat_mem[k] = 8'h00;
        live_pos = fresh_positions();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[r]) begin
            repeat (dir_tab[r].reps)
                send_beat(dir_tab[r].cmd, dir_tab[r].sym, dir_tab[r].fixed, dir_tab[r].want);
        end
        dir_beats = beats_taken;

        while (beats_taken < dir_beats + RAND_ITEMS) begin
            // one long receiver hold-off partway through, so the output
            // buffer fills and input stall has to rise
            if (!hold_req && beats_taken > dir_beats + 250)
                hold_req = 1'b1;
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                // noise: any command, pattern edits landing mid-text
                n = $urandom_range(1, 6);
                repeat (n) send_beat(t_cmd'($urandom_range(0, 3)), pick_pat_byte());
            end else begin
                if (sel < 6) begin
                    send_beat(CMD_CLEAR, 8'($urandom));
                    // mostly short patterns, now and then one past capacity
                    n = ($urandom_range(0, 15) == 0) ? $urandom_range(28, MAX_PAT + 4)
                                                     : $urandom_range(0, 8);
                    repeat (n) send_beat(CMD_APPEND, pick_pat_byte());
                end
                n = $urandom_range(1, 4);
                repeat (n) begin
                    if ($urandom_range(0, 9) < 6) begin
                        // text built by walking the pattern's units, rare slips
                        p = 0;
                        while (p < pat_len) begin
                            b = pat_mem[p];
                            if (starred(p)) begin
                                repeat ($urandom_range(0, 3))
                                    send_beat(CMD_TEXT, (b == ANY_BYTE) ? 8'($urandom) : b);
                                p += 2;
                            end else begin
                                if ($urandom_range(0, 24) == 0)
                                    b = pick_text_byte();
                                send_beat(CMD_TEXT, (b == ANY_BYTE) ? 8'($urandom) : b);
                                p++;
                            end
                        end
                    end else begin
                        repeat ($urandom_range(0, 8)) send_beat(CMD_TEXT, pick_text_byte());
                    end
                    send_beat(CMD_FINISH, 8'($urandom));
                end
            end
        end
        i_in_valid <= 1'b0;

        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        n_bad += pending_verdicts.size();
        if (n_bad == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: stall modes of random length, plus the single hold-off
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                mode_left = $urandom_range(10, 80);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 30;
                    2:       stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            mode_left--;
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result check: each taken beat against the oldest queued verdict
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got_verdict = '{o_matched, o_overflow};
            if (pending_verdicts.size() == 0) begin
                if (n_bad < REPORT_MAX)
                    $display("unexpected result beat: m=%0b o=%0b",
                             got_verdict.matched, got_verdict.overflow);
                n_bad++;
            end else begin
                want_verdict = pending_verdicts.pop_front();
                if (got_verdict !== want_verdict) begin
                    if (n_bad < REPORT_MAX)
                        $display("result mismatch: exp m=%0b o=%0b, got m=%0b o=%0b",
                                 want_verdict.matched, want_verdict.overflow,
                                 got_verdict.matched, got_verdict.overflow);
                    n_bad++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long with no beat on either channel
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule
